[sv/amar_pkg.sv]
`default_nettype none

package amar_pkg;

   // Fixed field widths of the streaming ports
   localparam int VALUE_W = 32;
   localparam int INDEX_W = 12;

   // Configuration port
   localparam int CSR_ADDR_W = 2;
   localparam int CSR_DATA_W = 17;

   localparam logic [CSR_ADDR_W-1:0] REG_INNER_COUNT = 2'd0;
   localparam logic [CSR_ADDR_W-1:0] REG_AXIS_SIZE   = 2'd1;
   localparam logic [CSR_ADDR_W-1:0] REG_OUTER_COUNT = 2'd2;
   localparam logic [CSR_ADDR_W-1:0] REG_SIGNED_MODE = 2'd3;

   localparam int INNER_REG_W = 11;
   localparam int AXIS_REG_W  = 13;
   localparam int OUTER_REG_W = 17;

   // Outer dimension limits
   localparam int OUTER_LIMIT = 65536;
   localparam int OUTER_POS_W = 16;

   // Result queue
   localparam int QDEPTH  = 3;
   localparam int QPTR_W  = 2;
   localparam int QCNT_W  = 2;

   typedef struct packed {
      logic [VALUE_W-1:0] value;
      logic [INDEX_W-1:0] index;
      logic               final_flag;
   } rsp_entry_type;

endpackage

`default_nettype wire

[sv/axis_max_argmax_reduce_unit.sv]
`default_nettype none

// Channel  Direction  Handshake          Payload
// req      in         req_valid/stall    req_element_value
// rsp      out        rsp_valid/stall    rsp_max_value, rsp_max_index, rsp_is_final
// csr      in         csr_valid/ready    csr_index, csr_data
//
// One element is taken per cycle while req_stall is low. Each element is read
// from the best-value memory at acceptance, compared and written back in the
// next cycle; a single write forwarding register covers back-to-back hits on
// the same entry. Results pass through a three-entry queue, so req_stall rises only
// when that queue could overflow. Synchronous reset clears counters and queue and
// presets configuration; the memory is not cleared: the first slice writes it all.
module axis_max_argmax_reduce_unit
   import amar_pkg::*;
#(
   parameter int INNER_MAX = 1024,
   parameter int AXIS_MAX  = 4096,
   parameter int DATA_W    = 32
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire logic [VALUE_W-1:0]    req_element_value,
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output logic [VALUE_W-1:0]         rsp_max_value,
   output logic [INDEX_W-1:0]         rsp_max_index,
   output logic                       rsp_is_final,
   input  wire logic                  csr_valid,
   output logic                       csr_ready,
   input  wire logic [CSR_ADDR_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_data
);

   localparam int AW     = (INNER_MAX > 1) ? $clog2(INNER_MAX) : 1;
   localparam int SP_W   = (AXIS_MAX > 1) ? $clog2(AXIS_MAX) : 1;
   localparam int NI_W   = $clog2(INNER_MAX + 1);
   localparam int NA_W   = $clog2(AXIS_MAX + 1);
   localparam int VAL_W  = (DATA_W < VALUE_W) ? DATA_W : VALUE_W;
   localparam bit SIGN_ON = (DATA_W <= VALUE_W);
   localparam int MEM_W  = SP_W + VAL_W;

   // ---------------------------------------------------------------
   // Configuration registers, held in clamped form
   logic [NI_W-1:0]        n_inner_ff, n_inner_in;
   logic [NA_W-1:0]        n_axis_ff, n_axis_in;
   logic [OUTER_REG_W-1:0] n_outer_ff, n_outer_in;
   logic                   signed_mode_ff, signed_mode_in;
   logic [31:0]            wr_inner, wr_axis, wr_outer;

   assign csr_ready = 1'b1;

   always_comb begin
      wr_inner       = 32'(csr_data[INNER_REG_W-1:0]);
      wr_axis        = 32'(csr_data[AXIS_REG_W-1:0]);
      wr_outer       = 32'(csr_data[OUTER_REG_W-1:0]);
      n_inner_in     = n_inner_ff;
      n_axis_in      = n_axis_ff;
      n_outer_in     = n_outer_ff;
      signed_mode_in = signed_mode_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            REG_INNER_COUNT: begin
               if (wr_inner == 32'd0)
                  n_inner_in = NI_W'(1);
               else if (wr_inner > 32'(INNER_MAX))
                  n_inner_in = NI_W'(INNER_MAX);
               else
                  n_inner_in = NI_W'(wr_inner);
            end
            REG_AXIS_SIZE: begin
               if (wr_axis == 32'd0)
                  n_axis_in = NA_W'(1);
               else if (wr_axis > 32'(AXIS_MAX))
                  n_axis_in = NA_W'(AXIS_MAX);
               else
                  n_axis_in = NA_W'(wr_axis);
            end
            REG_OUTER_COUNT: begin
               if (wr_outer == 32'd0)
                  n_outer_in = OUTER_REG_W'(1);
               else if (wr_outer > 32'(OUTER_LIMIT))
                  n_outer_in = OUTER_REG_W'(OUTER_LIMIT);
               else
                  n_outer_in = OUTER_REG_W'(wr_outer);
            end
            REG_SIGNED_MODE: signed_mode_in = csr_data[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         n_inner_ff     <= NI_W'(1);
         n_axis_ff      <= NA_W'(1);
         n_outer_ff     <= OUTER_REG_W'(1);
         signed_mode_ff <= 1'b1;
      end else begin
         n_inner_ff     <= n_inner_in;
         n_axis_ff      <= n_axis_in;
         n_outer_ff     <= n_outer_in;
         signed_mode_ff <= signed_mode_in;
      end
   end

   // ---------------------------------------------------------------
   // Position counters, advanced on each accepted beat
   logic [AW-1:0]          ip_ff, ip_in;
   logic [SP_W-1:0]        sp_ff, sp_in;
   logic [OUTER_POS_W-1:0] op_ff, op_in;
   logic                   last_inner, last_slice, last_outer;
   logic                   req_accept;
   logic [AW-1:0]          rd_addr;

   assign req_accept = req_valid && !req_stall;

   always_comb begin
      last_inner = (32'(ip_ff) + 32'd1) >= 32'(n_inner_ff);
      last_slice = (32'(sp_ff) + 32'd1) >= 32'(n_axis_ff);
      last_outer = (32'(op_ff) + 32'd1) >= 32'(n_outer_ff);
      rd_addr    = (32'(ip_ff) >= 32'(INNER_MAX)) ? '0 : ip_ff;
      ip_in      = ip_ff;
      sp_in      = sp_ff;
      op_in      = op_ff;
      if (req_accept) begin
         if (last_inner) begin
            ip_in = '0;
            if (last_slice) begin
               sp_in = '0;
               op_in = last_outer ? '0 : op_ff + OUTER_POS_W'(1);
            end else begin
               sp_in = sp_ff + SP_W'(1);
            end
         end else begin
            ip_in = ip_ff + AW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ip_ff <= '0;
         sp_ff <= '0;
         op_ff <= '0;
      end else begin
         ip_ff <= ip_in;
         sp_ff <= sp_in;
         op_ff <= op_in;
      end
   end

   // ---------------------------------------------------------------
   // Compare stage: beat details alongside the memory read
   logic             s1_valid_ff, s1_valid_in;
   logic [AW-1:0]    s1_addr_ff, s1_addr_in;
   logic [VAL_W-1:0] s1_value_ff, s1_value_in;
   logic [SP_W-1:0]  s1_slice_ff, s1_slice_in;
   logic             s1_first_ff, s1_first_in;
   logic             s1_last_ff, s1_last_in;
   logic             s1_final_ff, s1_final_in;

   always_comb begin
      s1_valid_in = req_accept;
      s1_addr_in  = rd_addr;
      s1_value_in = req_element_value[VAL_W-1:0];
      s1_slice_in = sp_ff;
      s1_first_in = (sp_ff == '0);
      s1_last_in  = last_slice;
      s1_final_in = last_inner && last_outer;
   end

   always_ff @(posedge clock) begin
      if (reset)
         s1_valid_ff <= 1'b0;
      else
         s1_valid_ff <= s1_valid_in;
   end

   always_ff @(posedge clock) begin
      s1_addr_ff  <= s1_addr_in;
      s1_value_ff <= s1_value_in;
      s1_slice_ff <= s1_slice_in;
      s1_first_ff <= s1_first_in;
      s1_last_ff  <= s1_last_in;
      s1_final_ff <= s1_final_in;
   end

   // ---------------------------------------------------------------
   // Best value / index memory, one read and one write port
   logic [MEM_W-1:0] best_mem_ff [INNER_MAX];
   logic [MEM_W-1:0] rd_data_ff;
   logic [MEM_W-1:0] new_entry;

   always_ff @(posedge clock) begin
      if (req_accept)
         rd_data_ff <= best_mem_ff[rd_addr];
      if (s1_valid_ff)
         best_mem_ff[s1_addr_ff] <= new_entry;
   end

   // Forwarding of the write landing in the same cycle as the read
   logic             fw_valid_ff, fw_valid_in;
   logic [AW-1:0]    fw_addr_ff, fw_addr_in;
   logic [MEM_W-1:0] fw_data_ff, fw_data_in;

   always_comb begin
      fw_valid_in = fw_valid_ff || s1_valid_ff;
      fw_addr_in  = s1_valid_ff ? s1_addr_ff : fw_addr_ff;
      fw_data_in  = s1_valid_ff ? new_entry : fw_data_ff;
   end

   always_ff @(posedge clock) begin
      if (reset)
         fw_valid_ff <= 1'b0;
      else
         fw_valid_ff <= fw_valid_in;
   end

   always_ff @(posedge clock) begin
      fw_addr_ff <= fw_addr_in;
      fw_data_ff <= fw_data_in;
   end

   // Compare and update
   logic [MEM_W-1:0] cur_entry;
   logic [VAL_W-1:0] cur_value;
   logic             flip;
   logic [VAL_W-1:0] cmp_new, cmp_cur;

   always_comb begin
      cur_entry = (fw_valid_ff && (fw_addr_ff == s1_addr_ff)) ? fw_data_ff : rd_data_ff;
      cur_value = cur_entry[VAL_W-1:0];
      flip      = signed_mode_ff && SIGN_ON;
      // Offset binary turns a signed compare into an unsigned one
      cmp_new   = {s1_value_ff[VAL_W-1] ^ flip, s1_value_ff[VAL_W-2:0]};
      cmp_cur   = {cur_value[VAL_W-1] ^ flip, cur_value[VAL_W-2:0]};
      if (s1_first_ff)
         new_entry = {SP_W'(0), s1_value_ff};
      else if (cmp_new > cmp_cur)
         new_entry = {s1_slice_ff, s1_value_ff};
      else
         new_entry = cur_entry;
   end

   // ---------------------------------------------------------------
   // Result queue
   rsp_entry_type           q_ff [QDEPTH];
   rsp_entry_type           q_new;
   logic [QPTR_W-1:0]       q_wr_ff, q_wr_in, q_rd_ff, q_rd_in;
   logic [QCNT_W-1:0]       q_cnt_ff, q_cnt_in;
   logic                    push, pop;

   assign push = s1_valid_ff && s1_last_ff;
   assign pop  = rsp_valid && !rsp_stall;

   always_comb begin
      q_new.value      = VALUE_W'(new_entry[VAL_W-1:0]);
      q_new.index      = INDEX_W'(new_entry[MEM_W-1:VAL_W]);
      q_new.final_flag = s1_final_ff;
      q_wr_in          = q_wr_ff;
      q_rd_in          = q_rd_ff;
      if (push)
         q_wr_in = (q_wr_ff == QPTR_W'(QDEPTH - 1)) ? '0 : q_wr_ff + QPTR_W'(1);
      if (pop)
         q_rd_in = (q_rd_ff == QPTR_W'(QDEPTH - 1)) ? '0 : q_rd_ff + QPTR_W'(1);
      q_cnt_in = q_cnt_ff + QCNT_W'(push) - QCNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         q_wr_ff  <= '0;
         q_rd_ff  <= '0;
         q_cnt_ff <= '0;
      end else begin
         q_wr_ff  <= q_wr_in;
         q_rd_ff  <= q_rd_in;
         q_cnt_ff <= q_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push)
         q_ff[q_wr_ff] <= q_new;
   end

   // Hold off input when queue plus the beat in flight could fill it
   assign req_stall     = (3'(q_cnt_ff) + 3'(push)) >= 3'(QDEPTH);
   assign rsp_valid     = (q_cnt_ff != '0);
   assign rsp_max_value = q_ff[q_rd_ff].value;
   assign rsp_max_index = q_ff[q_rd_ff].index;
   assign rsp_is_final  = q_ff[q_rd_ff].final_flag;

endmodule

`default_nettype wire
